// ----- rtl/ust_pkg.sv -----
// ----------------------------------------------------------------------------
// ust_pkg
// Shared types, command and status codes for the unordered set table.
// ----------------------------------------------------------------------------
`default_nettype none

package ust_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int KEY_WIDTH_DEF = 32;

   // Port field widths fixed by the channel definition
   localparam int KEY_PORT_W   = 32;
   localparam int COUNT_PORT_W = 5;

   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_CONTAINS = 2'd2;
   localparam logic [1:0] CMD_CLEAR    = 2'd3;

   localparam logic [1:0] ST_SUCCESS = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic cmp_en;     // latch the match of the key bus
      logic add_en;     // cell at the fill point takes the key bus
      logic remove_en;  // cells at or past the hit take their neighbour
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/ust_req_if.sv -----
// ----------------------------------------------------------------------------
// ust_req_if
// Command channel: valid/ready with command and key.
// ----------------------------------------------------------------------------
`default_nettype none

interface ust_req_if
   import ust_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [1:0]            cmd;
   logic [KEY_PORT_W-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

`default_nettype wire

// ----- rtl/ust_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ust_rsp_if
// Result channel: valid/ready with flag, status, count and empty flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ust_rsp_if
   import ust_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic [1:0]              status;
   logic [COUNT_PORT_W-1:0] count;
   logic                    is_empty;

   modport source (output valid, output ok, output status, output count,
                   output is_empty, input ready);
   modport sink   (input valid, input ok, input status, input count,
                   input is_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/ust_cell.sv -----
// ----------------------------------------------------------------------------
// ust_cell
// One slot of the set: holds a key, flags a match and shifts down on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module ust_cell
   import ust_pkg::*;
#(
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   parameter int CNT_W     = 5,
   parameter int INDEX     = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [CNT_W-1:0]     count,
   input  wire logic [KEY_WIDTH-1:0] key_bus,
   input  wire logic [KEY_WIDTH-1:0] next_entry,
   input  wire logic                 hit_in,
   output logic [KEY_WIDTH-1:0]      entry,
   output logic                      hit_out
);

   logic [KEY_WIDTH-1:0] entry_ff, entry_in;
   logic                 match_ff, match_in;
   logic                 occupied;

   assign occupied = CNT_W'(INDEX) < count;
   assign hit_out  = hit_in | match_ff;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = occupied && (entry_ff == key_bus);
      end
      if (ctrl.add_en && (CNT_W'(INDEX) == count)) begin
         entry_in = key_bus;
      end
      // take the neighbour's key from the hit onwards
      if (ctrl.remove_en && hit_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/unordered_set_table_unit.sv -----
// ----------------------------------------------------------------------------
// unordered_set_table_unit
// Set of distinct keys in a packed row of cells with a fill count.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Handshake   | Payload
//   --------+-----+-------------+-------------------------------------
//   req     | in  | valid/ready | cmd[1:0], key[31:0]
//   rsp     | out | valid/ready | ok, status[1:0], count[4:0], is_empty
//
// In the transfer cycle of a command the key is broadcast to every cell,
// which registers its own match; in the execute state, once the output is
// free, the hit ripples along the cell chain and the add, shift-down or
// clear is committed while the result is loaded into the output register.
// A result that is not taken holds the next command in its execute cycle;
// a new command is still taken while one result waits.
// Reset clears the fill count, the sequencer and the output valid; the keys
// in the cells are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module unordered_set_table_unit
   import ust_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ust_req_if.sink   req,
   ust_rsp_if.source rsp
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0]    key_ff, key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic [KEY_WIDTH-1:0]    req_key_ext;
   logic [KEY_WIDTH-1:0]    key_bus;
   logic                    req_xfer;
   logic                    out_free;
   logic                    commit;
   logic                    found;
   cell_ctrl_type           ctrl;

   logic [KEY_WIDTH-1:0]    entry [CAPACITY];
   logic [CAPACITY:0]       hit;

   // Fit the port key to the stored key width
   generate
      if (KEY_WIDTH >= KEY_PORT_W) begin : g_key_ext
         assign req_key_ext = KEY_WIDTH'(req.key);
      end else begin : g_key_trunc
         assign req_key_ext = req.key[KEY_WIDTH-1:0];
      end
   endgenerate

   assign req.ready = (state_ff == S_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign commit    = (state_ff == S_EXEC) && out_free;
   assign key_bus   = (state_ff == S_IDLE) ? req_key_ext : key_ff;
   assign found     = hit[CAPACITY];

   // Row of cells; the hit flag ripples from slot zero upwards
   assign hit[0] = 1'b0;

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [KEY_WIDTH-1:0] next_entry;
         if (i == CAPACITY - 1) begin : g_last
            assign next_entry = entry[i];
         end else begin : g_mid
            assign next_entry = entry[i+1];
         end

         ust_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .count      (count_ff),
            .key_bus    (key_bus),
            .next_entry (next_entry),
            .hit_in     (hit[i]),
            .entry      (entry[i]),
            .hit_out    (hit[i+1])
         );
      end
   endgenerate

   // Decide the outcome and drive the cell controls
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;
      ctrl          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               ctrl.cmp_en = 1'b1;
               cmd_in      = req.cmd;
               key_in      = req_key_ext;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               rsp_ok_in     = 1'b0;
               rsp_status_in = ST_SUCCESS;
               case (cmd_ff)
                  CMD_ADD: begin
                     if (found) begin
                        rsp_status_in = ST_PRESENT;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.add_en = 1'b1;
                        rsp_ok_in   = 1'b1;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (found) begin
                        ctrl.remove_en = 1'b1;
                        rsp_ok_in      = 1'b1;
                        count_in       = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = ST_ABSENT;
                     end
                  end
                  CMD_CONTAINS: begin
                     if (found) begin
                        rsp_ok_in = 1'b1;
                     end else begin
                        rsp_status_in = ST_ABSENT;
                     end
                  end
                  default: begin
                     // clear: drop the count, leave the keys
                     rsp_ok_in = 1'b1;
                     count_in  = '0;
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_count_in = count_in;
               rsp_empty_in = (count_in == '0);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Present the count in the port's width
   generate
      if (CNT_W >= COUNT_PORT_W) begin : g_cnt_trunc
         assign rsp.count = rsp_count_ff[COUNT_PORT_W-1:0];
      end else begin : g_cnt_ext
         assign rsp.count = {{(COUNT_PORT_W - CNT_W){1'b0}}, rsp_count_ff};
      end
   endgenerate

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.ok       = rsp_ok_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.is_empty = rsp_empty_ff;

endmodule

`default_nettype wire
